/* design/dtl_pkg.sv */
`timescale 1ns / 1ps

package dtl_pkg;

    localparam int COORD_BITS = 14;
    localparam int ID_BITS    = 8;
    localparam int GAP_BITS   = 10;
    localparam int WS_BITS    = 8;
    localparam int POS_BITS   = COORD_BITS + 1;
    // signed working width for split arithmetic
    localparam int CALC_BITS  = COORD_BITS + 3;
    localparam int CFG_BITS   = COORD_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_SIZE         = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_WORKSPACE = 2'd3;

    localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(1920);
    localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(1080);
    localparam logic [GAP_BITS-1:0]   RST_GAP_SIZE      = GAP_BITS'(8);
    localparam logic [WS_BITS-1:0]    RST_ACTIVE_WS     = '0;

    localparam logic signed [CALC_BITS-1:0] CALC_ONE = CALC_BITS'(1);

    typedef struct packed {
        logic [COORD_BITS-1:0] screen_width;
        logic [COORD_BITS-1:0] screen_height;
        logic [GAP_BITS-1:0]   gap_size;
        logic [WS_BITS-1:0]    active_workspace;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic               match;
        logic               last;
        logic [ID_BITS-1:0] id;
    } t_cmd;

    typedef struct packed {
        logic [ID_BITS-1:0]    placed_id;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_height;
        logic                  last_of_run;
    } t_place;

    typedef struct packed {
        logic flushing;
    } t_back_status;

    typedef enum logic {
        BK_RUN,
        BK_FLUSH
    } t_back_state;

    function automatic logic [COORD_BITS-1:0] at_least_one(
        input logic signed [CALC_BITS-1:0] v
    );
        return (v < CALC_ONE) ? COORD_BITS'(1) : v[COORD_BITS-1:0];
    endfunction

endpackage

/* design/dtl_ifs.sv */
`timescale 1ns / 1ps

interface dtl_entry_if;
    logic                         valid;
    logic                         ready;
    logic [dtl_pkg::ID_BITS-1:0]  window_id;
    logic [dtl_pkg::WS_BITS-1:0]  window_workspace;
    logic                         end_of_list;

    modport source (output valid, output window_id, output window_workspace,
                    output end_of_list, input ready);
    modport sink   (input valid, input window_id, input window_workspace,
                    input end_of_list, output ready);
endinterface

interface dtl_place_if;
    logic                            valid;
    logic                            ready;
    logic [dtl_pkg::ID_BITS-1:0]     placed_id;
    logic [dtl_pkg::POS_BITS-1:0]    pos_x;
    logic [dtl_pkg::POS_BITS-1:0]    pos_y;
    logic [dtl_pkg::COORD_BITS-1:0]  rect_width;
    logic [dtl_pkg::COORD_BITS-1:0]  rect_height;
    logic                            last_of_run;

    modport source (output valid, output placed_id, output pos_x, output pos_y,
                    output rect_width, output rect_height, output last_of_run,
                    input ready);
    modport sink   (input valid, input placed_id, input pos_x, input pos_y,
                    input rect_width, input rect_height, input last_of_run,
                    output ready);
endinterface

/* design/dtl_front.sv */
`timescale 1ns / 1ps

module dtl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dtl_entry_if.sink                   i_entry,
    input  logic [dtl_pkg::WS_BITS-1:0] i_active_ws,
    output logic                        o_cmd_valid,
    output dtl_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_ready
);

    logic          r_valid;
    dtl_pkg::t_cmd r_cmd;
    logic          take;

    assign i_entry.ready = !r_valid || i_cmd_ready;
    assign take          = i_entry.valid && i_entry.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.match <= (i_entry.window_workspace == i_active_ws);
            r_cmd.last  <= i_entry.end_of_list;
            r_cmd.id    <= i_entry.window_id;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

/* design/dtl_queue.sv */
`timescale 1ns / 1ps

module dtl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  dtl_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output dtl_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);

    dtl_pkg::t_cmd                     r_mem [dtl_pkg::QUEUE_DEPTH];
    logic [dtl_pkg::QPTR_BITS-1:0]     r_wptr;
    logic [dtl_pkg::QPTR_BITS-1:0]     r_rptr;
    logic [dtl_pkg::QCNT_BITS-1:0]     r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = (r_count != dtl_pkg::QCNT_BITS'(dtl_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rptr];

    function automatic logic [dtl_pkg::QPTR_BITS-1:0] bump(
        input logic [dtl_pkg::QPTR_BITS-1:0] p
    );
        return (p == dtl_pkg::QPTR_BITS'(dtl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= bump(r_wptr);
            end
            if (pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

/* design/dtl_back.sv */
`timescale 1ns / 1ps

module dtl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtl_pkg::t_cfg         i_cfg,
    input  logic                  i_cmd_valid,
    input  dtl_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_ready,
    dtl_place_if.source           o_place,
    output dtl_pkg::t_back_status o_status
);

    localparam int CB = dtl_pkg::CALC_BITS;
    localparam int PB = dtl_pkg::POS_BITS;

    dtl_pkg::t_back_state r_state, n_state;

    logic                           r_pv, n_pv;
    logic                           r_parity, n_parity;
    logic [dtl_pkg::ID_BITS-1:0]    r_pid, n_pid;
    logic [PB-1:0]                  r_px, n_px;
    logic [PB-1:0]                  r_py, n_py;
    logic [PB-1:0]                  r_pw, n_pw;
    logic [PB-1:0]                  r_ph, n_ph;
    logic                           r_out_valid, n_out_valid;
    dtl_pkg::t_place                r_out, n_out;
    logic                           out_load;

    logic                           slot_free;
    logic                           split_now;
    logic                           stall;

    logic signed [CB-1:0] g;
    logic signed [CB-1:0] len;
    logic signed [CB-1:0] diff;
    logic signed [CB-1:0] half;
    logic signed [CB-1:0] n_try;
    logic signed [CB-1:0] rest_try;
    logic signed [CB-1:0] n_keep;
    logic signed [CB-1:0] rest;
    logic signed [CB-1:0] adv;
    logic signed [CB-1:0] full_w;
    logic signed [CB-1:0] full_h;

    // split of the pending extent chosen by parity
    always_comb begin
        g        = signed'(CB'(i_cfg.gap_size));
        len      = signed'(CB'(r_parity ? r_ph : r_pw));
        diff     = len - g;
        // truncate toward zero
        half     = (diff + signed'(CB'(diff[CB-1]))) >>> 1;
        n_try    = (half < dtl_pkg::CALC_ONE) ? (len >>> 1) : half;
        rest_try = len - n_try - g;
        if (rest_try < dtl_pkg::CALC_ONE) begin
            rest   = dtl_pkg::CALC_ONE;
            n_keep = diff - dtl_pkg::CALC_ONE;
        end else begin
            rest   = rest_try;
            n_keep = n_try;
        end
        adv      = n_keep + g;
        full_w   = signed'(CB'(i_cfg.screen_width))  - (g <<< 1);
        full_h   = signed'(CB'(i_cfg.screen_height)) - (g <<< 1);
    end

    assign slot_free = !r_out_valid || o_place.ready;
    assign split_now = i_cmd.match && r_pv;
    assign stall     = split_now && !slot_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtl_pkg::BK_RUN: begin
                if (i_cmd_valid && !stall && i_cmd.last) begin
                    n_state = dtl_pkg::BK_FLUSH;
                end
            end
            dtl_pkg::BK_FLUSH: begin
                if (!r_pv || slot_free) begin
                    n_state = dtl_pkg::BK_RUN;
                end
            end
        endcase
    end

    // datapath and handshake
    always_comb begin
        n_pv        = r_pv;
        n_parity    = r_parity;
        n_pid       = r_pid;
        n_px        = r_px;
        n_py        = r_py;
        n_pw        = r_pw;
        n_ph        = r_ph;
        n_out       = r_out;
        out_load    = 1'b0;
        o_cmd_ready = 1'b0;
        n_out_valid = r_out_valid && !o_place.ready;

        unique case (r_state)
            dtl_pkg::BK_RUN: begin
                if (i_cmd_valid && !stall) begin
                    o_cmd_ready = !i_cmd.last;
                    if (i_cmd.match && !r_pv) begin
                        n_pv     = 1'b1;
                        n_pid    = i_cmd.id;
                        n_px     = PB'(i_cfg.gap_size);
                        n_py     = PB'(i_cfg.gap_size);
                        n_pw     = PB'(dtl_pkg::at_least_one(full_w));
                        n_ph     = PB'(dtl_pkg::at_least_one(full_h));
                        n_parity = 1'b0;
                    end else if (split_now) begin
                        out_load          = 1'b1;
                        n_out.placed_id   = r_pid;
                        n_out.pos_x       = r_px;
                        n_out.pos_y       = r_py;
                        n_out.last_of_run = 1'b0;
                        n_pid             = i_cmd.id;
                        if (!r_parity) begin
                            n_out.rect_width  = dtl_pkg::at_least_one(n_keep);
                            n_out.rect_height = dtl_pkg::at_least_one(signed'(CB'(r_ph)));
                            n_px              = PB'(signed'(CB'(r_px)) + adv);
                            n_pw              = PB'(rest);
                            n_parity          = 1'b1;
                        end else begin
                            n_out.rect_width  = dtl_pkg::at_least_one(signed'(CB'(r_pw)));
                            n_out.rect_height = dtl_pkg::at_least_one(n_keep);
                            n_py              = PB'(signed'(CB'(r_py)) + adv);
                            n_ph              = PB'(rest);
                            n_parity          = 1'b0;
                        end
                    end
                end
            end
            dtl_pkg::BK_FLUSH: begin
                if (!r_pv || slot_free) begin
                    o_cmd_ready = 1'b1;
                    if (r_pv) begin
                        out_load          = 1'b1;
                        n_out.placed_id   = r_pid;
                        n_out.pos_x       = r_px;
                        n_out.pos_y       = r_py;
                        n_out.rect_width  = dtl_pkg::at_least_one(signed'(CB'(r_pw)));
                        n_out.rect_height = dtl_pkg::at_least_one(signed'(CB'(r_ph)));
                        n_out.last_of_run = 1'b1;
                    end
                    n_pv     = 1'b0;
                    n_parity = 1'b0;
                    n_pid    = '0;
                    n_px     = '0;
                    n_py     = '0;
                    n_pw     = '0;
                    n_ph     = '0;
                end
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtl_pkg::BK_RUN;
            r_pv        <= 1'b0;
            r_parity    <= 1'b0;
            r_pid       <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_pw        <= '0;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_parity    <= n_parity;
            r_pid       <= n_pid;
            r_px        <= n_px;
            r_py        <= n_py;
            r_pw        <= n_pw;
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_place.valid       = r_out_valid;
    assign o_place.placed_id   = r_out.placed_id;
    assign o_place.pos_x       = r_out.pos_x;
    assign o_place.pos_y       = r_out.pos_y;
    assign o_place.rect_width  = r_out.rect_width;
    assign o_place.rect_height = r_out.rect_height;
    assign o_place.last_of_run = r_out.last_of_run;

    assign o_status.flushing = (r_state == dtl_pkg::BK_FLUSH);

endmodule

/* design/dwindle_tile_layout.sv */
// path: a split placement passes the front register, the queue and the output register; a flush goes via BK_FLUSH
// throughput: one entry per cycle while the output accepts; each end-of-list entry also passes BK_FLUSH
// the back end's single output register sets the pace when two placements fall on one entry
// reset: synchronous active-low i_rst_n clears the queue, pending rectangle and output valid
// reset also restores the registers to 1920 x 1080, gap 8, workspace 0
`timescale 1ns / 1ps

module dwindle_tile_layout (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dtl_entry_if.sink                           i_entry,
    dtl_place_if.source                         o_place,
    input  logic                                i_cfg_we,
    input  logic [dtl_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [dtl_pkg::CFG_BITS-1:0]        i_cfg_data
);

    dtl_pkg::t_cfg         r_cfg;
    logic                  front_valid;
    dtl_pkg::t_cmd         front_cmd;
    logic                  front_ready;
    logic                  cmd_valid;
    dtl_pkg::t_cmd         cmd;
    logic                  cmd_ready;
    dtl_pkg::t_back_status back_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width     <= dtl_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height    <= dtl_pkg::RST_SCREEN_HEIGHT;
            r_cfg.gap_size         <= dtl_pkg::RST_GAP_SIZE;
            r_cfg.active_workspace <= dtl_pkg::RST_ACTIVE_WS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtl_pkg::CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[dtl_pkg::COORD_BITS-1:0];
                end
                dtl_pkg::CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[dtl_pkg::COORD_BITS-1:0];
                end
                dtl_pkg::CFG_GAP_SIZE: begin
                    r_cfg.gap_size <= i_cfg_data[dtl_pkg::GAP_BITS-1:0];
                end
                dtl_pkg::CFG_ACTIVE_WORKSPACE: begin
                    r_cfg.active_workspace <= i_cfg_data[dtl_pkg::WS_BITS-1:0];
                end
            endcase
        end
    end

    dtl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (i_entry),
        .i_active_ws (r_cfg.active_workspace),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    dtl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (cmd_valid),
        .o_pop_cmd    (cmd),
        .i_pop_ready  (cmd_ready)
    );

    dtl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_place     (o_place),
        .o_status    (back_status)
    );

`ifndef SYNTH
    // the end-mark request stays at the queue head until its flush is done
    a_flush_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.flushing |-> (cmd_valid && cmd.last))
        else $error("flush without end-mark request at queue head");

    a_flush_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_status.flushing && !cmd_ready) |=> back_status.flushing)
        else $error("flush left without popping its request");

    a_reset_no_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_place.valid)
        else $error("placement valid right after reset");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT      = 37;

    typedef struct packed {
        logic [dtl_pkg::ID_BITS-1:0] id;
        logic [dtl_pkg::WS_BITS-1:0] ws;
        logic                        last;
    } t_entry;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [dtl_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [dtl_pkg::CFG_BITS-1:0]     i_cfg_data;

    dtl_entry_if entry_ch ();
    dtl_place_if place_ch ();

    dwindle_tile_layout dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (entry_ch),
        .o_place    (place_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_entry          entries_todo[$];
    t_entry          entry_on_bus;
    bit              entry_held;
    dtl_pkg::t_place placements_due[$];
    int              err_count;
    int              cycle_count;
    bit              no_idle;

    // layout registers as the block should hold them
    int scr_w, scr_h, gap_px, act_ws;

    // pending rectangle of the current list
    bit has_rect;
    int rect_id, rect_x, rect_y, rect_w, rect_h;
    bit halve_height;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic void note_due(input dtl_pkg::t_place p);
        placements_due = {placements_due, p};
    endfunction

    function automatic int split_first(input int len, input int g, output int rest);
        int n;
        n = (len - g) / 2;
        if (n < 1)
            n = len / 2;
        rest = len - n - g;
        if (rest < 1) begin
            rest = 1;
            n = len - g - 1;
        end
        return n;
    endfunction

    function automatic dtl_pkg::t_place make_placement(input int id, x, y, w, h,
                                                       input bit last);
        dtl_pkg::t_place p;
        p.placed_id   = dtl_pkg::ID_BITS'(id);
        p.pos_x       = dtl_pkg::POS_BITS'(x);
        p.pos_y       = dtl_pkg::POS_BITS'(y);
        p.rect_width  = dtl_pkg::COORD_BITS'((w < 1) ? 1 : w);
        p.rect_height = dtl_pkg::COORD_BITS'((h < 1) ? 1 : h);
        p.last_of_run = last;
        return p;
    endfunction

    function automatic void lay_out_entry(input t_entry e);
        int n;
        int rest;
        if (int'(e.ws) == act_ws) begin
            if (!has_rect) begin
                has_rect     = 1'b1;
                rect_id      = int'(e.id);
                rect_x       = gap_px;
                rect_y       = gap_px;
                rect_w       = scr_w - 2 * gap_px;
                rect_h       = scr_h - 2 * gap_px;
                if (rect_w < 1) rect_w = 1;
                if (rect_h < 1) rect_h = 1;
                halve_height = 1'b0;
            end else if (!halve_height) begin
                n = split_first(rect_w, gap_px, rest);
                note_due(make_placement(rect_id, rect_x, rect_y, n, rect_h, 1'b0));
                rect_id      = int'(e.id);
                rect_x       = rect_x + n + gap_px;
                rect_w       = rest;
                halve_height = 1'b1;
            end else begin
                n = split_first(rect_h, gap_px, rest);
                note_due(make_placement(rect_id, rect_x, rect_y, rect_w, n, 1'b0));
                rect_id      = int'(e.id);
                rect_y       = rect_y + n + gap_px;
                rect_h       = rest;
                halve_height = 1'b0;
            end
        end
        if (e.last) begin
            if (has_rect)
                note_due(make_placement(rect_id, rect_x, rect_y, rect_w, rect_h, 1'b1));
            has_rect     = 1'b0;
            rect_id      = 0;
            rect_x       = 0;
            rect_y       = 0;
            rect_w       = 0;
            rect_h       = 0;
            halve_height = 1'b0;
        end
    endfunction

    // entry driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_ch.valid <= 1'b0;
        end else begin
            if (entry_ch.valid && entry_ch.ready) begin
                lay_out_entry(entry_on_bus);
                entry_held = 1'b0;
            end
            if (!entry_ch.valid || entry_ch.ready) begin
                if (entries_todo.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    entry_on_bus = entries_todo.pop_front();
                    entry_held   = 1'b1;
                    entry_ch.valid            <= 1'b1;
                    entry_ch.window_id        <= entry_on_bus.id;
                    entry_ch.window_workspace <= entry_on_bus.ws;
                    entry_ch.end_of_list      <= entry_on_bus.last;
                end else begin
                    entry_ch.valid <= 1'b0;
                end
            end
        end
    end

    // placement monitor
    always @(posedge i_clk) begin
        dtl_pkg::t_place want;
        if (!i_rst_n) begin
            place_ch.ready <= 1'b0;
        end else begin
            if (place_ch.valid && place_ch.ready) begin
                if (placements_due.size() == 0) begin
                    report_mismatch($sformatf("placement for id %0d with none due",
                                              place_ch.placed_id));
                end else begin
                    want = placements_due.pop_front();
                    if (place_ch.placed_id !== want.placed_id)
                        report_mismatch($sformatf("placed_id %0d, wanted %0d",
                                                  place_ch.placed_id, want.placed_id));
                    if (place_ch.pos_x !== want.pos_x)
                        report_mismatch($sformatf("pos_x %0d, wanted %0d",
                                                  $signed(place_ch.pos_x), $signed(want.pos_x)));
                    if (place_ch.pos_y !== want.pos_y)
                        report_mismatch($sformatf("pos_y %0d, wanted %0d",
                                                  $signed(place_ch.pos_y), $signed(want.pos_y)));
                    if (place_ch.rect_width !== want.rect_width)
                        report_mismatch($sformatf("rect_width %0d, wanted %0d",
                                                  place_ch.rect_width, want.rect_width));
                    if (place_ch.rect_height !== want.rect_height)
                        report_mismatch($sformatf("rect_height %0d, wanted %0d",
                                                  place_ch.rect_height, want.rect_height));
                    if (place_ch.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, wanted %0b",
                                                  place_ch.last_of_run, want.last_of_run));
                end
            end
            place_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [dtl_pkg::CFG_IDX_BITS-1:0] idx, input int value);
        logic [dtl_pkg::CFG_BITS-1:0] d;
        d = dtl_pkg::CFG_BITS'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            dtl_pkg::CFG_SCREEN_WIDTH:     scr_w  = int'(d[dtl_pkg::COORD_BITS-1:0]);
            dtl_pkg::CFG_SCREEN_HEIGHT:    scr_h  = int'(d[dtl_pkg::COORD_BITS-1:0]);
            dtl_pkg::CFG_GAP_SIZE:         gap_px = int'(d[dtl_pkg::GAP_BITS-1:0]);
            dtl_pkg::CFG_ACTIVE_WORKSPACE: act_ws = int'(d[dtl_pkg::WS_BITS-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_layout(input int w, input int h, input int g, input int ws);
        write_reg(dtl_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(dtl_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(dtl_pkg::CFG_GAP_SIZE, g);
        write_reg(dtl_pkg::CFG_ACTIVE_WORKSPACE, ws);
    endtask

    function automatic void queue_entry(input int id, input int ws, input bit last);
        t_entry e;
        e.id   = dtl_pkg::ID_BITS'(id);
        e.ws   = dtl_pkg::WS_BITS'(ws);
        e.last = last;
        entries_todo = {entries_todo, e};
    endfunction

    // mostly well-formed lists, with stray foreign entries and loose noise
    task automatic queue_random(input int count);
        int added;
        int len;
        int k;
        int ws;
        bit last;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 80) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0)
                        queue_entry($urandom_range(255), $urandom_range(255), 1'b0);
                    last = (k == len - 1);
                    ws = (last && $urandom_range(7) == 0) ? $urandom_range(255) : act_ws;
                    queue_entry($urandom_range(255), ws, last);
                    added++;
                end
            end else begin
                ws   = ($urandom_range(1) == 0) ? act_ws : $urandom_range(255);
                last = 1'($urandom_range(1));
                queue_entry($urandom_range(255), ws, last);
                if (ws == act_ws || last)
                    added++;
            end
        end
    endtask

    // no result may follow an end mark with nothing pending, so settle afterwards
    task automatic wait_idle();
        while (entries_todo.size() != 0 || entry_held || placements_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        err_count    = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        entry_held   = 1'b0;
        scr_w        = 1920;
        scr_h        = 1080;
        gap_px       = 8;
        act_ws       = 0;
        has_rect     = 1'b0;
        rect_id      = 0;
        rect_x       = 0;
        rect_y       = 0;
        rect_w       = 0;
        rect_h       = 0;
        halve_height = 1'b0;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        entry_ch.valid            = 1'b0;
        entry_ch.window_id        = '0;
        entry_ch.window_workspace = '0;
        entry_ch.end_of_list      = 1'b0;
        place_ch.ready            = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset layout: single window, width and height splits, split plus flush
        queue_entry(0, 0, 1'b1);
        queue_entry(255, 0, 1'b0);
        queue_entry(1, 0, 1'b0);
        queue_entry(2, 0, 1'b0);
        queue_entry(3, 5, 1'b0);
        queue_entry(4, 0, 1'b1);
        // end mark on a foreign workspace still flushes
        queue_entry(10, 0, 1'b0);
        queue_entry(11, 7, 1'b1);
        // end marks with nothing pending
        queue_entry(12, 9, 1'b1);
        queue_entry(14, 3, 1'b1);
        wait_idle();

        // gaps larger than the screen: clamps and split fallbacks
        set_layout(1, 1, 1023, 255);
        queue_entry(0, 255, 1'b0);
        queue_entry(1, 255, 1'b0);
        queue_entry(2, 255, 1'b0);
        queue_entry(3, 255, 1'b1);
        wait_idle();

        // largest screen, no gap, upper data bits dropped by narrow registers
        set_layout(16383, 16383, 'h3c00, 'h3f00);
        queue_entry(20, 0, 1'b0);
        queue_entry(21, 0, 1'b0);
        queue_entry(22, 0, 1'b0);
        queue_entry(23, 0, 1'b0);
        queue_entry(24, 0, 1'b1);
        wait_idle();

        // zero width screen
        set_layout(0, 3, 1, 170);
        queue_entry(30, 170, 1'b0);
        queue_entry(31, 170, 1'b0);
        queue_entry(32, 170, 1'b1);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_layout(1920, 1080, 8, $urandom_range(255));
                1: set_layout(16383, 16383, 0, 255);
                2: set_layout($urandom_range(1, 16383), $urandom_range(1, 16383),
                              $urandom_range(0, 1023), 0);
                3: set_layout($urandom_range(1, 40), $urandom_range(1, 40),
                              $urandom_range(0, 30), $urandom_range(255));
                4: set_layout($urandom_range(1, 16383), $urandom_range(1, 16383),
                              $urandom_range(0, 16383), $urandom_range(0, 16383));
                default: set_layout($urandom_range(100, 4000), $urandom_range(100, 4000),
                                    $urandom_range(0, 1023), $urandom_range(255));
            endcase
            no_idle = (ph == 2);
            queue_random(65);
            wait_idle();
        end
        no_idle = 1'b0;

        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
design/dtl_pkg.sv
design/dtl_ifs.sv
design/dtl_front.sv
design/dtl_queue.sv
design/dtl_back.sv
design/dwindle_tile_layout.sv
bench/tb.sv
